// ===== design/ukt_pkg.sv =====
// ukt_pkg: shared types and constants of the unordered key table
// no dependencies; imported by unordered_key_table_top and ukt_checker
`timescale 1ns / 1ps
`default_nettype none

package ukt_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_SEARCH     = 2'd1,
    ACT_REMOVE     = 2'd2,
    ACT_REMOVE_ALL = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entries_used;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/unordered_key_table_top.sv =====
// unordered_key_table_top: packed unordered key table with insert, search and removes
// depends on ukt_pkg
`timescale 1ns / 1ps
`default_nettype none

// A request carries an action and a key; each request gives exactly one response with
// ok, found_index and the entry count after the request. Keys live in slots
// 0 .. entries_used-1 of one synchronous key memory (one read, one write a cycle).
// Insert appends at the end without a walk. Search, remove and remove-all walk the
// memory from slot 0 at one entry per cycle; each entry removed adds a pass through
// ST_LAST, where the last entry, fetched by the scan, is moved into the freed slot,
// and remove-all re-checks the moved entry in the same cycle as the move. The walk
// through the single read port sets how fast requests finish. A new request is taken
// only when the previous one has left the walk; a finished response may still be
// waiting in the output register. The key memory needs no clearing after reset, so
// requests are taken right away. capacity may be written only while the block is idle;
// values above DEPTH act as DEPTH and 0 makes every insert fail.
module unordered_key_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ukt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ukt_pkg::rsp_t      rsp,
  input  wire logic          cfg_we,
  input  wire logic [ukt_pkg::CNT_W-1:0] cfg_data
);
  import ukt_pkg::*;

  // key memory, read data registered
  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic                 mem_we;

  state_t state, state_next;

  // request context
  logic [1:0]           act, act_next;
  logic [KEY_WIDTH-1:0] key_reg, key_next;
  logic [IDX_W-1:0]     cur, cur_next;       // slot whose data sits in rdata
  logic [CNT_W-1:0]     used, used_next;
  logic                 ok_acc, ok_next;
  logic [IDX_W-1:0]     found, found_next;
  logic [CNT_W-1:0]     capacity;

  logic             accept;
  logic             hit;
  logic [CNT_W-1:0] cur_inc;
  logic [CNT_W-1:0] used_dec;
  logic [CNT_W-1:0] used_dec2;
  logic [CNT_W-1:0] eff_cap;
  logic             last_done;
  logic             again;
  logic             cont;
  logic             rsp_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign hit       = (rdata == key_reg);
  assign cur_inc   = {1'b0, cur} + CNT_W'(1);
  assign used_dec  = used - CNT_W'(1);
  assign used_dec2 = used - CNT_W'(2);
  assign eff_cap   = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  // moved-in last entry: slot cur was the last one, or it needs another drop, or walk on
  assign last_done = ({1'b0, cur} >= used_dec);
  assign again     = (act == ACT_REMOVE_ALL) && hit && !last_done;
  assign cont      = (act == ACT_REMOVE_ALL) && !hit && !last_done && (cur_inc < used_dec);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == ACT_INSERT || used == '0) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (act == ACT_SEARCH) ? ST_RESP : ST_LAST;
        end else if (cur_inc < used) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_LAST: begin
        if (again) begin
          state_next = ST_LAST;
        end else if (cont) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory addressing and request context
  always_comb begin
    raddr      = cur;
    mem_we     = 1'b0;
    waddr      = cur;
    wdata      = rdata;
    act_next   = act;
    key_next   = key_reg;
    cur_next   = cur;
    used_next  = used;
    ok_next    = ok_acc;
    found_next = found;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          act_next   = req.action;
          key_next   = req.key;
          ok_next    = 1'b0;
          found_next = '0;
          cur_next   = '0;
          raddr      = '0;
          if (req.action == ACT_INSERT && used < eff_cap) begin
            mem_we    = 1'b1;
            waddr     = used[IDX_W-1:0];
            wdata     = req.key;
            used_next = used + CNT_W'(1);
            ok_next   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (act == ACT_SEARCH) begin
            ok_next    = 1'b1;
            found_next = cur;
          end else begin
            raddr = used_dec[IDX_W-1:0];  // fetch the last entry
          end
        end else if (cur_inc < used) begin
          raddr    = cur_inc[IDX_W-1:0];
          cur_next = cur_inc[IDX_W-1:0];
        end
      end
      ST_LAST: begin
        // rdata holds the last entry: move it into slot cur and shrink
        mem_we    = 1'b1;
        waddr     = cur;
        wdata     = rdata;
        used_next = used_dec;
        ok_next   = 1'b1;
        if (again) begin
          raddr = used_dec2[IDX_W-1:0];
        end else if (cont) begin
          raddr    = cur_inc[IDX_W-1:0];
          cur_next = cur_inc[IDX_W-1:0];
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      capacity  <= CNT_W'(DEPTH);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (state == ST_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act     <= act_next;
    key_reg <= key_next;
    cur     <= cur_next;
    ok_acc  <= ok_next;
    found   <= found_next;
    if (state == ST_RESP && rsp_free) begin
      rsp.ok           <= ok_acc;
      rsp.found_index  <= found;
      rsp.entries_used <= used;
    end
  end

endmodule

`default_nettype wire

// ===== design/ukt_checker.sv =====
// ukt_checker: port-level assertions for the unordered key table, bound to the top level
// depends on ukt_pkg and unordered_key_table_top
`timescale 1ns / 1ps
`default_nettype none

module ukt_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire ukt_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire ukt_pkg::rsp_t rsp,
  input wire logic          cfg_we,
  input wire logic [ukt_pkg::CNT_W-1:0] cfg_data
);
  import ukt_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in progress");

  // a miss or failure reports slot 0
  a_miss_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.found_index == '0)
    else $error("nonzero index on failed request");

  // a reported slot lies inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found_index != '0 |-> {1'b0, rsp.found_index} < rsp.entries_used)
    else $error("found index beyond entry count");

endmodule

bind unordered_key_table_top ukt_checker u_ukt_checker (.*);

`default_nettype wire

// ===== test/unordered_key_table_top_test.sv =====
// unordered_key_table_top_test: self-checking bench for the unordered key table
// drives insert, search and remove requests over several capacity settings
// depends on ukt_pkg and unordered_key_table_top
`timescale 1ns / 1ps

module unordered_key_table_top_test;
  import ukt_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_AT = 100;       // response count that starts the long stall
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  unordered_key_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // requests waiting to be driven, responses waiting to come back
  req_t pending_reqs[$];
  rsp_t awaited_rsps[$];

  // mirror of the table contents and the capacity register
  logic [KEY_WIDTH-1:0] key_mirror [DEPTH];
  int                   key_count = 0;
  logic [CNT_W-1:0]     cap_setting = 7'd64;

  // idle percentages for each side, changed only between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int mismatch_count = 0;
  int rsp_seen = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  // small key pool so that searches hit and duplicates pile up
  logic [KEY_WIDTH-1:0] key_pool [6];

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: mismatch: %s", $time, msg);
  endtask

  // apply one request to the mirror and return the response it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   slot;
    int   limit;
    res = '0;
    // capacity above the table size saturates, zero blocks every insert
    limit = (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
    case (action_t'(r.action))
      ACT_INSERT: begin
        if (key_count < limit) begin
          key_mirror[key_count] = r.key;
          key_count++;
          res.ok = 1'b1;
        end
      end
      ACT_SEARCH: begin
        for (slot = 0; slot < key_count; slot++) begin
          if (key_mirror[slot] == r.key) begin
            res.ok = 1'b1;
            res.found_index = slot[IDX_W-1:0];
            break;
          end
        end
      end
      ACT_REMOVE: begin
        // the last entry fills the hole left by the first match
        for (slot = 0; slot < key_count; slot++) begin
          if (key_mirror[slot] == r.key) begin
            key_mirror[slot] = key_mirror[key_count-1];
            key_count--;
            res.ok = 1'b1;
            break;
          end
        end
      end
      ACT_REMOVE_ALL: begin
        // stay on the slot after a move so the moved-in key gets checked too
        slot = 0;
        while (slot < key_count) begin
          if (key_mirror[slot] == r.key) begin
            key_mirror[slot] = key_mirror[key_count-1];
            key_count--;
            res.ok = 1'b1;
          end else begin
            slot++;
          end
        end
      end
    endcase
    res.entries_used = key_count[CNT_W-1:0];
    return res;
  endfunction

  // driver: holds valid and payload until the request is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready)
        awaited_rsps.push_back(apply_request(req));
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each response against the oldest prediction and drives ready
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (awaited_rsps.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding, entries_used %0d",
                                    rsp.entries_used));
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch($sformatf("ok got %0b expected %0b", rsp.ok, want.ok));
          if (rsp.found_index !== want.found_index)
            report_mismatch($sformatf("found_index got %0d expected %0d",
                                      rsp.found_index, want.found_index));
          if (rsp.entries_used !== want.entries_used)
            report_mismatch($sformatf("entries_used got %0d expected %0d",
                                      rsp.entries_used, want.entries_used));
        end
      end
      // one long stall so the block backs up and drops req_ready
      if (rsp_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("unordered_key_table_top test failed");
      $finish;
    end
  end

  task automatic queue_request(action_t act, logic [KEY_WIDTH-1:0] k);
    req_t r;
    r.action = act;
    r.key = k;
    pending_reqs.push_back(r);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(5))
        0: key_pool[i] = '0;
        1: key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(99) < 12)
      return $urandom;
    return key_pool[$urandom_range(5)];
  endfunction

  // random requests in bursts that lean toward filling or draining the table
  task automatic queue_random(int n);
    int queued;
    int burst;
    int insert_pct;
    queued = 0;
    while (queued < n) begin
      burst = $urandom_range(8, 40);
      case ($urandom_range(2))
        0: insert_pct = 15;
        1: insert_pct = 45;
        default: insert_pct = 80;
      endcase
      if ($urandom_range(3) == 0)
        refresh_pool();
      for (int i = 0; i < burst && queued < n; i++) begin
        if ($urandom_range(99) < insert_pct)
          queue_request(ACT_INSERT, pick_key());
        else
          queue_request(action_t'($urandom_range(1, 3)), pick_key());
        queued++;
      end
    end
  endtask

  // wait until every request has been driven and answered
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    cap_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    refresh_pool();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 22;
    recv_idle_pct = 72;

    // empty table: every lookup and removal misses
    queue_request(ACT_SEARCH, 32'h0);
    queue_request(ACT_REMOVE, 32'h0);
    queue_request(ACT_REMOVE_ALL, 32'hFFFF_FFFF);
    // extremes of the key and a duplicate of each
    queue_request(ACT_INSERT, 32'h0);
    queue_request(ACT_INSERT, 32'hFFFF_FFFF);
    queue_request(ACT_INSERT, 32'h1234_5678);
    queue_request(ACT_INSERT, 32'h0);
    queue_request(ACT_INSERT, 32'hFFFF_FFFF);
    queue_request(ACT_SEARCH, 32'hFFFF_FFFF);
    queue_request(ACT_SEARCH, 32'h0);
    queue_request(ACT_SEARCH, 32'hDEAD_BEEF);
    // first match gets the last entry moved in
    queue_request(ACT_REMOVE, 32'h0);
    queue_request(ACT_SEARCH, 32'hFFFF_FFFF);
    queue_request(ACT_REMOVE, 32'hDEAD_BEEF);
    // the key moved into a freed slot matches as well
    queue_request(ACT_INSERT, 32'h1234_5678);
    queue_request(ACT_INSERT, 32'h1234_5678);
    queue_request(ACT_REMOVE_ALL, 32'h1234_5678);
    queue_request(ACT_SEARCH, 32'h1234_5678);
    queue_request(ACT_REMOVE_ALL, 32'hFFFF_FFFF);
    queue_request(ACT_SEARCH, 32'h0);
    queue_random(300);

    // single slot table
    write_capacity(7'd1);
    queue_request(ACT_INSERT, 32'hA5A5_A5A5);
    queue_request(ACT_INSERT, 32'h5A5A_5A5A);
    queue_random(80);

    // roles swapped: sender idles, receiver mostly ready
    drain();
    send_idle_pct = 72;
    recv_idle_pct = 22;

    // out of range capacity acts as a full size table
    write_capacity(7'd127);
    refresh_pool();
    repeat (70) queue_request(ACT_INSERT, pick_key());
    queue_random(240);

    // zero capacity with keys still held: inserts fail, removals still work
    write_capacity(7'd0);
    queue_random(60);

    // no idling on either side
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    write_capacity(7'd5);
    queue_random(150);

    write_capacity(7'd64);
    refresh_pool();
    repeat (70) queue_request(ACT_INSERT, pick_key());
    queue_request(ACT_REMOVE_ALL, key_pool[0]);
    queue_random(230);

    write_capacity(7'($urandom_range(2, 63)));
    queue_random(100);

    drain();
    repeat (DEPTH + 8) @(posedge clk);
    if (awaited_rsps.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", awaited_rsps.size()));
    if (mismatch_count == 0) begin
      $display("unordered_key_table_top test passed");
    end else begin
      $display("unordered_key_table_top test failed");
    end
    $finish;
  end

endmodule

// ===== unordered_key_table_top.f =====
design/ukt_pkg.sv
design/unordered_key_table_top.sv
design/ukt_checker.sv
test/unordered_key_table_top_test.sv
